// ===== hdl/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// Point-to-segment distance package
// Shared types and constants of the point-to-segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int COORD_BITS_DEF  = 32;
  localparam int T_FRAC_BITS_DEF = 16;
  localparam int DIST_BITS       = 33;

  typedef enum logic [1:0] {
    REGION_DEGEN    = 2'd0,
    REGION_START    = 2'd1,
    REGION_END      = 2'd2,
    REGION_INTERIOR = 2'd3
  } region_t;

  typedef struct packed {
    logic valid;
  } psd_ctl_t;

endpackage

// ===== hdl/psd_div_cell.sv =====
// ----------------------------------------------------------------------------
// Projection divider cell
// One restoring division step that yields one fraction bit of the projection
// parameter and hands the partial remainder to the next cell.
// ----------------------------------------------------------------------------
module psd_div_cell import psd_pkg::*; #(
  parameter int REM_W  = 67,
  parameter int T_W    = 17,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  psd_ctl_t          ctl_in,
  input  logic [REM_W-1:0]  rem_in,
  input  logic [REM_W-1:0]  den_in,
  input  logic [T_W-1:0]    t_in,
  input  logic [SIDE_W-1:0] side_in,
  output psd_ctl_t          ctl_out,
  output logic [REM_W-1:0]  rem_out,
  output logic [REM_W-1:0]  den_out,
  output logic [T_W-1:0]    t_out,
  output logic [SIDE_W-1:0] side_out
);

  logic [REM_W:0]   shifted;
  logic [REM_W:0]   diff;
  logic             ge;
  logic             valid_r;
  logic             valid_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [T_W-1:0]   t_r, t_nxt;
  logic [REM_W-1:0] den_r;
  logic [SIDE_W-1:0] side_r;

  always_comb begin
    shifted   = {rem_in, 1'b0};
    diff      = shifted - {1'b0, den_in};
    ge        = (shifted >= {1'b0, den_in});
    rem_nxt   = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
    t_nxt     = {t_in[T_W-2:0], ge};
    valid_nxt = ctl_in.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    t_r    <= t_nxt;
    den_r  <= den_in;
    side_r <= side_in;
  end

  assign ctl_out.valid = valid_r;
  assign rem_out       = rem_r;
  assign den_out       = den_r;
  assign t_out         = t_r;
  assign side_out      = side_r;

endmodule

// ===== hdl/psd_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// One digit-by-digit step of the integer square root: takes two radicand bits
// and decides one root bit.
// ----------------------------------------------------------------------------
module psd_sqrt_cell import psd_pkg::*; #(
  parameter int ROOT_W = 35,
  parameter int RAD_W  = 70,
  parameter int SIDE_W = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  psd_ctl_t          ctl_in,
  input  logic [ROOT_W+2:0] rem_in,
  input  logic [ROOT_W-1:0] root_in,
  input  logic [RAD_W-1:0]  rad_in,
  input  logic [SIDE_W-1:0] side_in,
  output psd_ctl_t          ctl_out,
  output logic [ROOT_W+2:0] rem_out,
  output logic [ROOT_W-1:0] root_out,
  output logic [RAD_W-1:0]  rad_out,
  output logic [SIDE_W-1:0] side_out
);

  logic [ROOT_W+2:0] cur;
  logic [ROOT_W+2:0] trial;
  logic              ge;
  logic              valid_r;
  logic              valid_nxt;
  logic [ROOT_W+2:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [SIDE_W-1:0] side_r;

  always_comb begin
    cur       = {rem_in[ROOT_W:0], rad_in[RAD_W-1:RAD_W-2]};
    trial     = {1'b0, root_in, 2'b01};
    ge        = (cur >= trial);
    rem_nxt   = ge ? (cur - trial) : cur;
    root_nxt  = {root_in[ROOT_W-2:0], ge};
    rad_nxt   = {rad_in[RAD_W-3:0], 2'b00};
    valid_nxt = ctl_in.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    rad_r  <= rad_nxt;
    side_r <= side_in;
  end

  assign ctl_out.valid = valid_r;
  assign rem_out       = rem_r;
  assign root_out      = root_r;
  assign rad_out       = rad_r;
  assign side_out      = side_r;

endmodule

// ===== hdl/point_segment_distance_top.sv =====
// ----------------------------------------------------------------------------
// Point-to-segment distance
// Pipeline that returns the floor square root distance from a query point to
// a segment, with a code for the nearest part of the segment.
//
//   Channel  Handshake              Payload
//   input    start (busy tied low)  in_start_x/y, in_end_x/y, in_query_x/y
//   result   out_valid strobe       out_distance, out_region
//
// A new transaction is taken in every cycle; busy never rises.
// Stages in order: differences, products, region, divider cell row, foot point,
// residual, squares, norm, square root cell row and output register.
// Reset clears only the valid bits of the pipeline.
// Each result is shown for one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module point_segment_distance_top import psd_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic signed [COORD_BITS-1:0] in_query_x,
  input  logic signed [COORD_BITS-1:0] in_query_y,
  output logic                         out_valid,
  output logic [DIST_BITS-1:0]         out_distance,
  output logic [1:0]                   out_region
);

  localparam int DW   = COORD_BITS + 1;
  localparam int PW   = 2 * DW;
  localparam int NW   = PW + 1;
  localparam int TW   = T_FRAC_BITS + 1;
  localparam int FW   = TW + 1 + DW;
  localparam int RW   = DW + 1;
  localparam int SQW  = 2 * RW;
  localparam int SW   = SQW + 1;
  localparam int QW   = SW + (SW % 2);
  localparam int RB   = QW / 2;
  localparam int SDW  = 6 * DW + 3;
  localparam int XW   = RB + DIST_BITS;

  // Stage 0: differences.
  logic                 v0_r;
  logic signed [DW-1:0] dx0_r, dy0_r, px0_r, py0_r, ex0_r, ey0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    dx0_r <= DW'(in_end_x) - DW'(in_start_x);
    dy0_r <= DW'(in_end_y) - DW'(in_start_y);
    px0_r <= DW'(in_query_x) - DW'(in_start_x);
    py0_r <= DW'(in_query_y) - DW'(in_start_y);
    ex0_r <= DW'(in_query_x) - DW'(in_end_x);
    ey0_r <= DW'(in_query_y) - DW'(in_end_y);
  end

  // Stage 1: products.
  logic                 v1_r;
  logic signed [PW-1:0] pxdx1_r, pydy1_r, dxdx1_r, dydy1_r;
  logic signed [DW-1:0] dx1_r, dy1_r, px1_r, py1_r, ex1_r, ey1_r;
  logic                 degen1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    pxdx1_r  <= px0_r * dx0_r;
    pydy1_r  <= py0_r * dy0_r;
    dxdx1_r  <= dx0_r * dx0_r;
    dydy1_r  <= dy0_r * dy0_r;
    dx1_r    <= dx0_r;
    dy1_r    <= dy0_r;
    px1_r    <= px0_r;
    py1_r    <= py0_r;
    ex1_r    <= ex0_r;
    ey1_r    <= ey0_r;
    degen1_r <= (dx0_r == '0) && (dy0_r == '0);
  end

  // Stage 2: dot product, squared length and region decision.
  logic signed [NW-1:0] num2;
  logic [NW-1:0]        den2;
  region_t              region2;
  logic                 full2;
  logic [NW-1:0]        rem2;

  always_comb begin
    num2  = NW'(pxdx1_r) + NW'(pydy1_r);
    den2  = NW'(unsigned'(dxdx1_r)) + NW'(unsigned'(dydy1_r));
    full2 = 1'b0;
    rem2  = '0;
    if (degen1_r) begin
      region2 = REGION_DEGEN;
    end else if (num2[NW-1]) begin
      region2 = REGION_START;
    end else if (den2 < unsigned'(num2)) begin
      region2 = REGION_END;
    end else begin
      region2 = REGION_INTERIOR;
      full2   = (unsigned'(num2) == den2);
      rem2    = full2 ? '0 : unsigned'(num2);
    end
  end

  psd_ctl_t               dctl  [T_FRAC_BITS+1];
  logic [NW-1:0]          drem  [T_FRAC_BITS+1];
  logic [NW-1:0]          dden  [T_FRAC_BITS+1];
  logic [TW-1:0]          dt    [T_FRAC_BITS+1];
  logic [SDW-1:0]         dside [T_FRAC_BITS+1];
  logic                   v2_r;
  logic [NW-1:0]          rem2_r, den2_r;
  logic [SDW-1:0]         side2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    rem2_r  <= rem2;
    den2_r  <= den2;
    side2_r <= {px1_r, py1_r, dx1_r, dy1_r, ex1_r, ey1_r, region2, full2};
  end

  assign dctl[0].valid = v2_r;
  assign drem[0]       = rem2_r;
  assign dden[0]       = den2_r;
  assign dt[0]         = '0;
  assign dside[0]      = side2_r;

  for (genvar i = 0; i < T_FRAC_BITS; i++) begin : g_div
    psd_div_cell #(
      .REM_W  (NW),
      .T_W    (TW),
      .SIDE_W (SDW)
    ) u_div_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_in   (dctl[i]),
      .rem_in   (drem[i]),
      .den_in   (dden[i]),
      .t_in     (dt[i]),
      .side_in  (dside[i]),
      .ctl_out  (dctl[i+1]),
      .rem_out  (drem[i+1]),
      .den_out  (dden[i+1]),
      .t_out    (dt[i+1]),
      .side_out (dside[i+1])
    );
  end

  // Foot point: scaled offset along the segment.
  logic signed [DW-1:0] pxd, pyd, dxd, dyd, exd, eyd;
  logic [1:0]           regd;
  logic                 fulld;
  logic [TW-1:0]        tfin;

  always_comb begin
    {pxd, pyd, dxd, dyd, exd, eyd, regd, fulld} = dside[T_FRAC_BITS];
    tfin = fulld ? {1'b1, {T_FRAC_BITS{1'b0}}} : dt[T_FRAC_BITS];
  end

  logic                 vf1_r;
  logic signed [FW-1:0] fx1_r, fy1_r;
  logic signed [DW-1:0] pxf_r, pyf_r, exf_r, eyf_r;
  logic [1:0]           regf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf1_r <= 1'b0;
    end else begin
      vf1_r <= dctl[T_FRAC_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    fx1_r  <= $signed({1'b0, tfin}) * dxd;
    fy1_r  <= $signed({1'b0, tfin}) * dyd;
    pxf_r  <= pxd;
    pyf_r  <= pyd;
    exf_r  <= exd;
    eyf_r  <= eyd;
    regf_r <= regd;
  end

  // Residual vector from the nearest point to the query point.
  logic signed [FW-1:0] offx_w, offy_w;
  logic signed [RW-1:0] rxn, ryn;

  always_comb begin
    offx_w = fx1_r >>> T_FRAC_BITS;
    offy_w = fy1_r >>> T_FRAC_BITS;
    case (regf_r)
      REGION_END: begin
        rxn = RW'(exf_r);
        ryn = RW'(eyf_r);
      end
      REGION_INTERIOR: begin
        rxn = RW'(pxf_r) - offx_w[RW-1:0];
        ryn = RW'(pyf_r) - offy_w[RW-1:0];
      end
      default: begin
        rxn = RW'(pxf_r);
        ryn = RW'(pyf_r);
      end
    endcase
  end

  logic                 vr_r, vq_r, vn_r;
  logic signed [RW-1:0] rx_r, ry_r;
  logic [1:0]           regr_r, regq_r, regn_r;
  logic signed [SQW-1:0] sqx_r, sqy_r;
  logic [QW-1:0]        norm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vr_r <= 1'b0;
      vq_r <= 1'b0;
      vn_r <= 1'b0;
    end else begin
      vr_r <= vf1_r;
      vq_r <= vr_r;
      vn_r <= vq_r;
    end
  end

  always_ff @(posedge clk) begin
    rx_r   <= rxn;
    ry_r   <= ryn;
    regr_r <= regf_r;
    sqx_r  <= rx_r * rx_r;
    sqy_r  <= ry_r * ry_r;
    regq_r <= regr_r;
    norm_r <= QW'(SW'(unsigned'(sqx_r)) + SW'(unsigned'(sqy_r)));
    regn_r <= regq_r;
  end

  // Square root cell row.
  psd_ctl_t        sctl  [RB+1];
  logic [RB+2:0]   srem  [RB+1];
  logic [RB-1:0]   sroot [RB+1];
  logic [QW-1:0]   srad  [RB+1];
  logic [1:0]      sside [RB+1];

  assign sctl[0].valid = vn_r;
  assign srem[0]       = '0;
  assign sroot[0]      = '0;
  assign srad[0]       = norm_r;
  assign sside[0]      = regn_r;

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    psd_sqrt_cell #(
      .ROOT_W (RB),
      .RAD_W  (QW),
      .SIDE_W (2)
    ) u_sqrt_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_in   (sctl[j]),
      .rem_in   (srem[j]),
      .root_in  (sroot[j]),
      .rad_in   (srad[j]),
      .side_in  (sside[j]),
      .ctl_out  (sctl[j+1]),
      .rem_out  (srem[j+1]),
      .root_out (sroot[j+1]),
      .rad_out  (srad[j+1]),
      .side_out (sside[j+1])
    );
  end

  // Output register with saturation.
  logic [XW-1:0]        root_x;
  logic [DIST_BITS-1:0] dist_nxt;
  logic                 out_valid_r;
  logic [DIST_BITS-1:0] out_distance_r;
  logic [1:0]           out_region_r;

  always_comb begin
    root_x = XW'(sroot[RB]);
    if (root_x[XW-1:DIST_BITS] != '0) begin
      dist_nxt = '1;
    end else begin
      dist_nxt = root_x[DIST_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sctl[RB].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_distance_r <= dist_nxt;
    out_region_r   <= sside[RB];
  end

  assign busy         = 1'b0;
  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_region   = out_region_r;

endmodule
